// ===== rtl/plucked_string_synth_unit_defines.svh =====
// ----------------------------------------------------------------------------
// plucked string synth assertion macros
// shared concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_SYNTH_UNIT_DEFINES_SVH
`define PLUCKED_STRING_SYNTH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define PSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PSS_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PSS_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/pss_pkg.sv =====
// ----------------------------------------------------------------------------
// pss_pkg
// types, constants and arithmetic helpers of the plucked string voice
// ----------------------------------------------------------------------------
`default_nettype none

package pss_pkg;

  localparam int MAX_LENGTH = 2048;
  localparam int AW         = $clog2(MAX_LENGTH);

  localparam int OP_W   = 2;
  localparam int LEN_W  = 12;
  localparam int GAIN_W = 16;
  localparam int AMP_W  = 16;
  localparam int WIDX_W = 11;
  localparam int SW     = 16;

  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_GAIN   = 1'b1;

  localparam logic [LEN_W-1:0]  LEN_RESET  = 12'd100;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd64553;

  // product widths: gain x ring sum and amplitude x excitation
  localparam int PROD_T_W = GAIN_W + SW + 2;
  localparam int PROD_P_W = AMP_W + SW + 1;

  localparam int SAT_W = 20;
  localparam logic signed [SAT_W-1:0] SAT_HI = 20'sh07FFF;
  localparam logic signed [SAT_W-1:0] SAT_LO = 20'shF8000;

  typedef enum logic [OP_W-1:0] {
    OP_TICK  = 2'd0,
    OP_PLUCK = 2'd1,
    OP_LOAD  = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [AMP_W-1:0]         amplitude;
    logic [WIDX_W-1:0]        word_index;
    logic signed [SW-1:0]     excite_value;
    logic signed [SW-1:0]     mix_in;
  } item_t;

  typedef struct packed {
    logic                 valid;
    logic signed [SW-1:0] sample;
    logic                 clipped;
  } result_t;

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic                 clip;
  } sat_t;

  function automatic sat_t sat16(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SAT_HI) begin
      r.value = SAT_HI[SW-1:0];
      r.clip  = 1'b1;
    end else if (v < SAT_LO) begin
      r.value = SAT_LO[SW-1:0];
      r.clip  = 1'b1;
    end else begin
      r.value = v[SW-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

  // ring length clamped to [2, MAX_LENGTH]
  function automatic logic [AW:0] ring_len(input logic [LEN_W-1:0] dl);
    logic [AW:0] l;
    if (32'(dl) < 32'd2) begin
      l = (AW+1)'(2);
    end else if (32'(dl) > 32'(MAX_LENGTH)) begin
      l = (AW+1)'(MAX_LENGTH);
    end else begin
      l = (AW+1)'(dl);
    end
    return l;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pss_ram.sv =====
// ----------------------------------------------------------------------------
// pss_ram
// simple dual-port synchronous ram, one write and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pss_ctrl.sv =====
// ----------------------------------------------------------------------------
// pss_ctrl
// sequencer around the ring and excitation memories: clear, pluck, tick, load
// ----------------------------------------------------------------------------
`default_nettype none
`include "plucked_string_synth_unit_defines.svh"

module pss_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pss_pkg::item_t                item,
  input  logic [pss_pkg::LEN_W-1:0]     delay_length,
  input  logic [pss_pkg::GAIN_W-1:0]    decay_gain,
  input  logic                          len_wr,
  input  logic                          out_free,
  output pss_pkg::result_t              res
);

  localparam int AW = pss_pkg::AW;
  localparam int SW = pss_pkg::SW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PLUCK,
    S_DRAIN,
    S_TICK_MUL,
    S_TICK_WR
  } state_t;

  state_t state;

  logic [AW-1:0]                        pos;
  logic [AW:0]                          cnt;
  logic [pss_pkg::AMP_W-1:0]            amp;
  logic signed [SW-1:0]                 mix_r;
  logic [AW-1:0]                        tick_addr;
  logic signed [pss_pkg::PROD_T_W-1:0]  tick_prod;
  logic                                 p1_valid;
  logic [AW-1:0]                        p1_addr;
  logic                                 p2_valid;
  logic [AW-1:0]                        p2_addr;
  logic signed [pss_pkg::PROD_P_W-1:0]  p2_prod;

  logic [AW:0]     len;
  logic [AW:0]     pos_ext;
  logic [AW-1:0]   cur_pos;
  logic [AW:0]     nxt_ext;
  logic [AW-1:0]   nxt_pos;
  logic [AW:0]     cnt_inc;
  logic            accept;
  logic            tick_go;
  logic            pluck_go;
  logic            load_go;

  logic            dl_we;
  logic [AW-1:0]   dl_waddr;
  logic [AW:0]     dl_waddr_ext;
  logic [SW-1:0]   dl_wdata;
  logic            ex_we;
  logic            ex_re;
  logic [SW-1:0]   cur_raw;
  logic [SW-1:0]   nxt_raw;
  logic [SW-1:0]   exc_raw;

  logic signed [SW-1:0]              cur;
  logic signed [SW-1:0]              nxt;
  logic signed [SW-1:0]              exc;
  logic signed [SW:0]                ring_sum;
  logic signed [SW:0]                mix_sum;
  logic signed [pss_pkg::PROD_T_W:0] tick_biased;
  logic signed [pss_pkg::PROD_P_W:0] pluck_biased;
  pss_pkg::sat_t                     tick_sat;
  pss_pkg::sat_t                     pluck_sat;
  pss_pkg::sat_t                     mix_sat;

  assign len      = pss_pkg::ring_len(delay_length);
  assign pos_ext  = {1'b0, pos};
  assign cur_pos  = (pos_ext >= len) ? '0 : pos;
  assign nxt_ext  = {1'b0, cur_pos} + (AW+1)'(1);
  assign nxt_pos  = (nxt_ext >= len) ? '0 : nxt_ext[AW-1:0];
  assign cnt_inc  = cnt + (AW+1)'(1);

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign tick_go  = accept && (item.opcode == pss_pkg::OP_TICK);
  assign pluck_go = accept && (item.opcode == pss_pkg::OP_PLUCK);
  assign load_go  = accept && (item.opcode == pss_pkg::OP_LOAD);

  assign ex_we = load_go && (32'(item.word_index) < 32'(pss_pkg::MAX_LENGTH));
  assign ex_re = (state == S_PLUCK);

  assign cur = $signed(cur_raw);
  assign nxt = $signed(nxt_raw);
  assign exc = $signed(exc_raw);

  // loop filter: decay_gain * (cur + nxt) / 2^17, round half up
  assign ring_sum    = (SW+1)'(cur) + (SW+1)'(nxt);
  assign tick_biased = (pss_pkg::PROD_T_W+1)'(tick_prod) + (pss_pkg::PROD_T_W+1)'(65536);
  assign tick_sat    = pss_pkg::sat16(pss_pkg::SAT_W'(
                         $signed(tick_biased[pss_pkg::PROD_T_W:17])));

  // excitation scaling: amplitude * exc / 2^15, round half up
  assign pluck_biased = (pss_pkg::PROD_P_W+1)'(p2_prod) + (pss_pkg::PROD_P_W+1)'(16384);
  assign pluck_sat    = pss_pkg::sat16(pss_pkg::SAT_W'(
                          $signed(pluck_biased[pss_pkg::PROD_P_W:15])));

  assign mix_sum = (SW+1)'(mix_r) + (SW+1)'(cur);
  assign mix_sat = pss_pkg::sat16(pss_pkg::SAT_W'(mix_sum));

  assign res.valid   = (state == S_TICK_MUL) && out_free;
  assign res.sample  = mix_sat.value;
  assign res.clipped = mix_sat.clip;

  // ring write port: clear sweep, pluck pipeline or tick write-back
  always_comb begin
    dl_we    = 1'b0;
    dl_waddr = tick_addr;
    dl_wdata = tick_sat.value;
    if (state == S_CLEAR) begin
      dl_we    = 1'b1;
      dl_waddr = cnt[AW-1:0];
      dl_wdata = '0;
    end else if (p2_valid) begin
      dl_we    = 1'b1;
      dl_waddr = p2_addr;
      dl_wdata = pluck_sat.value;
    end else if (state == S_TICK_WR) begin
      dl_we    = 1'b1;
    end
  end

  assign dl_waddr_ext = {1'b0, dl_waddr};

  // two copies of the ring so that both taps are read in the same cycle
  pss_ram #(
    .WIDTH (SW),
    .DEPTH (pss_pkg::MAX_LENGTH)
  ) u_ring_cur (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .re    (tick_go),
    .raddr (cur_pos),
    .rdata (cur_raw)
  );

  pss_ram #(
    .WIDTH (SW),
    .DEPTH (pss_pkg::MAX_LENGTH)
  ) u_ring_nxt (
    .clk   (clk),
    .we    (dl_we),
    .waddr (dl_waddr),
    .wdata (dl_wdata),
    .re    (tick_go),
    .raddr (nxt_pos),
    .rdata (nxt_raw)
  );

  pss_ram #(
    .WIDTH (SW),
    .DEPTH (pss_pkg::MAX_LENGTH)
  ) u_excite (
    .clk   (clk),
    .we    (ex_we),
    .waddr (AW'(item.word_index)),
    .wdata (item.excite_value),
    .re    (ex_re),
    .raddr (cnt[AW-1:0]),
    .rdata (exc_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      pos      <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else begin
      p1_valid <= 1'b0;
      p2_valid <= p1_valid;
      if (p1_valid) begin
        p2_prod <= $signed({1'b0, amp}) * exc;
        p2_addr <= p1_addr;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt_inc;
          if (cnt[AW-1:0] == AW'(pss_pkg::MAX_LENGTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (tick_go) begin
            tick_addr <= nxt_pos;
            pos       <= nxt_pos;
            mix_r     <= item.mix_in;
            state     <= S_TICK_MUL;
          end else if (pluck_go) begin
            amp   <= item.amplitude;
            pos   <= '0;
            cnt   <= '0;
            state <= S_PLUCK;
          end
        end
        S_PLUCK: begin
          p1_valid <= 1'b1;
          p1_addr  <= cnt[AW-1:0];
          cnt      <= cnt_inc;
          if (cnt_inc == len) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last product is written in this cycle when stage one is empty
          if (!p1_valid) begin
            state <= S_IDLE;
          end
        end
        S_TICK_MUL: begin
          // ram read data holds while the output side is full
          if (out_free) begin
            tick_prod <= $signed({1'b0, decay_gain}) * ring_sum;
            state     <= S_TICK_WR;
          end
        end
        S_TICK_WR: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (len_wr) begin
        pos <= '0;
      end
    end
  end

  `PSS_ASSERT_IMP(a_pos_in_ring, clk, rst, 1'b1, pos_ext < len, "read position beyond ring length")
  `PSS_ASSERT_IMP(a_wr_in_ring, clk, rst, dl_we && (state != S_CLEAR), dl_waddr_ext < len, "ring write beyond ring length")
  `PSS_ASSERT_IMP(a_no_wr_clash, clk, rst, p2_valid, state != S_TICK_WR, "pluck and tick writes overlap")
  `PSS_ASSERT_NXT(a_tick_to_mul, clk, rst, tick_go, state == S_TICK_MUL, "tick did not reach multiply step")
  `PSS_ASSERT_IMP(a_res_after_tick, clk, rst, res.valid, $past(state) == S_IDLE || $past(state) == S_TICK_MUL, "result without a tick")

endmodule

`default_nettype wire

// ===== rtl/plucked_string_synth_unit.sv =====
// ----------------------------------------------------------------------------
// plucked_string_synth_unit
// karplus-strong string voice: ring delay line with averaging loop filter
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries commands; tuser is the opcode (tick, pluck, load).
//   a tick gives one sample on m_axis; pluck and load give none.
//   cfg writes delay_length (index 0) or decay_gain (index 1); cfg_ready is
//   always high, writes are expected only while the voice is idle.
// sequencing:
//   tick: both taps are read, the multiply step loads the output register and
//   the new ring value is written back; input is ready again after write-back.
//   pluck: one ring entry per cycle through a two-stage read / multiply pipeline
//   on the excitation memory, ready again once it drains. load: written at once.
// reset:
//   the ring memory is cleared by a sweep over all 2048 entries, one entry a cycle;
//   s_axis_tready stays low until it is done, configuration is still taken.
// stalls:
//   one result waits in the output register while the next command is taken;
//   a second tick holds in its multiply step until that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module plucked_string_synth_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // amplitude, word_index, excite_value, mix_in, zero pad
  input  logic [pss_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // opcode
  input  logic [pss_pkg::OP_W-1:0]          s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // sample_out
  output logic [pss_pkg::TDATA_OUT_W-1:0]   m_axis_tdata,
  // clipped
  output logic [0:0]                        m_axis_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [pss_pkg::LEN_W-1:0]  delay_length;
  logic [pss_pkg::GAIN_W-1:0] decay_gain;
  logic                       out_valid;
  logic signed [pss_pkg::SW-1:0] out_sample;
  logic                       out_clip;

  pss_pkg::item_t   item;
  pss_pkg::result_t res;
  logic             out_free;
  logic             cfg_wr;
  logic             len_wr;

  assign item.opcode       = pss_pkg::opcode_t'(s_axis_tuser);
  assign item.amplitude    = s_axis_tdata[15:0];
  assign item.word_index   = s_axis_tdata[26:16];
  assign item.excite_value = $signed(s_axis_tdata[42:27]);
  assign item.mix_in       = $signed(s_axis_tdata[58:43]);

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign len_wr    = cfg_wr && (cfg_index == pss_pkg::CFG_DELAY_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_length <= pss_pkg::LEN_RESET;
      decay_gain   <= pss_pkg::GAIN_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        pss_pkg::CFG_DELAY_LENGTH: delay_length <= cfg_data[pss_pkg::LEN_W-1:0];
        pss_pkg::CFG_DECAY_GAIN:   decay_gain   <= cfg_data[pss_pkg::GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register frees up in the cycle its transaction completes
  assign out_free = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_sample <= res.sample;
      out_clip   <= res.clipped;
    end
  end

  assign m_axis_tvalid   = out_valid;
  assign m_axis_tdata    = out_sample;
  assign m_axis_tuser[0] = out_clip;

  pss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .item         (item),
    .delay_length (delay_length),
    .decay_gain   (decay_gain),
    .len_wr       (len_wr),
    .out_free     (out_free),
    .res          (res)
  );

endmodule

`default_nettype wire

// ===== tb/tb_plucked_string_synth_unit.sv =====
// ----------------------------------------------------------------------------
// tb_plucked_string_synth_unit
// Self-checking bench for the plucked string voice. A directed table covers
// reset state, extremes, saturation and length clamping. Random phases then
// follow at several ring lengths and loop gains. Every accepted command goes
// through a local model of the ring, and each output sample is checked
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_plucked_string_synth_unit;
  import pss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              LONG_HOLD   = 400;
  localparam int unsigned     CYCLE_LIMIT = 2_000_000;

  // command word as carried on s_axis_tdata, amp in the lowest bits
  typedef struct packed {
    logic [TDATA_IN_W-AMP_W-WIDX_W-2*SW-1:0] pad;
    logic signed [SW-1:0]                    mix;
    logic signed [SW-1:0]                    exc;
    logic [WIDX_W-1:0]                       widx;
    logic [AMP_W-1:0]                        amp;
  } cmd_word_t;

  typedef struct {
    logic [SW-1:0] sample;
    bit            clip;
  } sample_rec_t;

  typedef enum bit {ROW_CMD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic [OP_W-1:0]   op;
    logic [15:0]       arg;    // amplitude, or register value
    logic [WIDX_W-1:0] widx;   // word index, or register index
    logic [SW-1:0]     exc;
    logic [SW-1:0]     mix;
    bit                typed;
    logic [SW-1:0]     exp_sample;
    bit                exp_clip;
  } step_row_t;

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [0:0]             m_axis_tuser;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // model of the voice
  logic signed [SW-1:0] ring_model   [MAX_LENGTH];
  logic signed [SW-1:0] excite_model [MAX_LENGTH];
  logic [AW-1:0]        pos_model;
  logic [LEN_W-1:0]     len_model;
  logic [GAIN_W-1:0]    gain_model;

  sample_rec_t sample_q[$];

  // typed-in expectation travelling with the command in flight
  bit            chk_typed;
  logic [SW-1:0] chk_sample;
  bit            chk_clip;

  bit          excite_loaded [MAX_LENGTH];
  int unsigned loaded_prefix;
  int unsigned active_len;
  int unsigned src_gap_max;
  int unsigned sink_gap_max;
  bit          stall_sink_req;

  int          errors;
  int unsigned cycle_cnt;
  int unsigned samples_seen, clips_seen, plucks_seen, loads_seen, reg_writes;

  step_row_t dir_rows [27] = '{
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h0000, 1'b1, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b0},
    '{ROW_CMD, OP_UNUSED, 16'hFFFF, 11'h7FF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_REG, OP_TICK,   16'd4,    CFG_DELAY_LENGTH, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CMD, OP_LOAD,   16'h0000, 11'd0,   16'h7FFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_LOAD,   16'h0000, 11'd1,   16'h8000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_LOAD,   16'h0000, 11'd2,   16'h0001, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_LOAD,   16'h0000, 11'd3,   16'hFFFF, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_LOAD,   16'hA5A5, 11'h7FF, 16'h5A5A, 16'h5A5A, 1'b0, 16'h0000, 1'b0},
    // unity pluck copies the excitation
    '{ROW_CMD, OP_PLUCK,  16'h8000, 11'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h0001, 1'b1, 16'h7FFF, 1'b1},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    // amplitude above one saturates the ring
    '{ROW_CMD, OP_PLUCK,  16'hFFFF, 11'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h0000, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h7FFF, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_PLUCK,  16'h0000, 11'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h8000, 1'b1, 16'h8000, 1'b0},
    // length below two clamps up, zero gain kills the loop
    '{ROW_REG, OP_TICK,   16'd0,    CFG_DELAY_LENGTH, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_REG, OP_TICK,   16'd0,    CFG_DECAY_GAIN,   16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CMD, OP_PLUCK,  16'h8000, 11'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h0000, 1'b1, 16'h7FFF, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    // full gain, length above the maximum clamps down
    '{ROW_REG, OP_TICK,   16'hFFFF, CFG_DECAY_GAIN,   16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_REG, OP_TICK,   16'h0FFF, CFG_DELAY_LENGTH, 16'h0, 16'h0, 1'b0, 16'h0, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{ROW_CMD, OP_TICK,   16'h0000, 11'd0,   16'h0000, 16'h8000, 1'b0, 16'h0000, 1'b0}
  };

  plucked_string_synth_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic int unsigned span_of(input logic [LEN_W-1:0] len);
    if (len < 2) return 2;
    if (len > MAX_LENGTH) return MAX_LENGTH;
    return len;
  endfunction

  function automatic logic [SW-1:0] clamp_sample(input longint v, output bit hit);
    hit = 1'b1;
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    hit = 1'b0;
    return v[SW-1:0];
  endfunction

  // advance the ring model by one command, returns the sample a tick makes
  function automatic void voice_step(input logic [OP_W-1:0] op, input cmd_word_t w,
                                     output bit made, output logic [SW-1:0] smp,
                                     output bit hit);
    int unsigned span, cur_at, nxt_at;
    longint      acc;
    bit          drop;
    span = span_of(len_model);
    made = 1'b0;
    smp  = '0;
    hit  = 1'b0;
    case (op)
      OP_LOAD: begin
        excite_model[w.widx] = w.exc;
        loads_seen++;
      end
      OP_PLUCK: begin
        pos_model = '0;
        for (int i = 0; i < span; i++) begin
          acc = longint'(w.amp) * longint'(excite_model[i]);
          ring_model[i] = clamp_sample((acc + 64'sd16384) >>> 15, drop);
        end
        plucks_seen++;
      end
      OP_TICK: begin
        cur_at = (pos_model >= span) ? 0 : pos_model;
        nxt_at = (cur_at + 1 >= span) ? 0 : cur_at + 1;
        smp = clamp_sample(longint'(w.mix) + longint'(ring_model[cur_at]), hit);
        acc = longint'(gain_model) *
              (longint'(ring_model[cur_at]) + longint'(ring_model[nxt_at]));
        ring_model[nxt_at] = clamp_sample((acc + 64'sd65536) >>> 17, drop);
        pos_model = nxt_at[AW-1:0];
        made = 1'b1;
      end
      default: ;
    endcase
  endfunction

  function automatic logic [SW-1:0] rand_mix();
    if ($urandom_range(0, 1) == 0) return 16'($urandom);
    return 16'(int'($urandom_range(0, 4096)) - 2048);
  endfunction

  // prediction and checking on every accepted transaction
  always @(posedge clk) begin
    cmd_word_t     w;
    bit            made, hit;
    logic [SW-1:0] smp;
    sample_rec_t   want;
    if (rst) begin
      for (int i = 0; i < MAX_LENGTH; i++) begin
        ring_model[i]   = '0;
        excite_model[i] = '0;
      end
      pos_model  = '0;
      len_model  = LEN_RESET;
      gain_model = GAIN_RESET;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sample_q.size() == 0) begin
          $error("sample_out %0d arrived with no sample pending", $signed(m_axis_tdata));
          errors++;
        end else begin
          want = sample_q.pop_front();
          if (m_axis_tdata !== want.sample) begin
            $error("sample_out: expected %0d, got %0d",
                   $signed(want.sample), $signed(m_axis_tdata));
            errors++;
          end
          if (m_axis_tuser[0] !== want.clip) begin
            $error("clipped: expected %0b, got %0b", want.clip, m_axis_tuser[0]);
            errors++;
          end
          samples_seen++;
          if (want.clip) clips_seen++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_DELAY_LENGTH) begin
          len_model = cfg_data[LEN_W-1:0];
          pos_model = '0;
        end else if (cfg_index == CFG_DECAY_GAIN) begin
          gain_model = cfg_data[GAIN_W-1:0];
        end
        reg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        w = s_axis_tdata;
        voice_step(s_axis_tuser, w, made, smp, hit);
        if (made) begin
          want.sample = chk_typed ? chk_sample : smp;
          want.clip   = chk_typed ? chk_clip : hit;
          sample_q.push_back(want);
        end
      end
    end
  end

  // output side: short random stalls after each transaction, one long hold
  initial begin
    int unsigned gap;
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk);
      if (stall_sink_req) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        m_axis_tready <= 1'b1;
        stall_sink_req = 1'b0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        gap = $urandom_range(0, sink_gap_max);
        if (gap != 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
          m_axis_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d samples pending", cycle_cnt, sample_q.size());
      $display("tb_plucked_string_synth_unit NOT OK");
      $finish;
    end
  end

  task automatic push_item(input logic [OP_W-1:0] op, input cmd_word_t w, input bit typed,
                           input logic [SW-1:0] exp_sample, input bit exp_clip);
    int unsigned gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= w;
    chk_typed     <= typed;
    chk_sample    <= exp_sample;
    chk_clip      <= exp_clip;
    if (op == OP_LOAD) begin
      excite_loaded[w.widx] = 1'b1;
      while (loaded_prefix < MAX_LENGTH && excite_loaded[loaded_prefix]) loaded_prefix++;
    end
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // stop sending, let every sample come out and a pluck run to its end
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk);
    repeat (active_len + 16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DELAY_LENGTH) active_len = span_of(data[LEN_W-1:0]);
  endtask

  initial begin
    cmd_word_t        w;
    logic [OP_W-1:0]  op;
    logic [LEN_W-1:0] len_sel;
    logic [15:0]      gain_sel;
    int unsigned      r;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = OP_TICK;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_DELAY_LENGTH;
    cfg_data       = '0;
    chk_typed      = 1'b0;
    chk_sample     = '0;
    chk_clip       = 1'b0;
    stall_sink_req = 1'b0;
    loaded_prefix  = 0;
    active_len     = span_of(LEN_RESET);
    src_gap_max    = 6;
    sink_gap_max   = 6;
    errors         = 0;
    cycle_cnt      = 0;
    samples_seen   = 0;
    clips_seen     = 0;
    plucks_seen    = 0;
    loads_seen     = 0;
    reg_writes     = 0;
    rst            = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        write_reg(dir_rows[i].widx[CFG_IDX_W-1:0], dir_rows[i].arg);
      end else begin
        w.pad  = '0;
        w.amp  = dir_rows[i].arg;
        w.widx = dir_rows[i].widx;
        w.exc  = dir_rows[i].exc;
        w.mix  = dir_rows[i].mix;
        push_item(dir_rows[i].op, w, dir_rows[i].typed,
                  dir_rows[i].exp_sample, dir_rows[i].exp_clip);
      end
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       len_sel = 12'd2;
        1:       len_sel = 12'($urandom_range(3, 16));
        2:       len_sel = 12'hFFF;
        3:       len_sel = 12'($urandom_range(17, 64));
        4:       len_sel = 12'd1;
        6:       len_sel = 12'd2048;
        7:       len_sel = 12'($urandom_range(65, 200));
        8:       len_sel = 12'($urandom_range(2, 12));
        default: len_sel = 12'($urandom_range(2, 32));
      endcase
      case (ph % 4)
        0:       gain_sel = 16'hFFFF;
        1:       gain_sel = 16'h0000;
        default: gain_sel = 16'($urandom);
      endcase
      write_reg(CFG_DELAY_LENGTH, 16'(len_sel));
      write_reg(CFG_DECAY_GAIN, gain_sel);
      src_gap_max  = (ph % 3 == 2 || ph == 3) ? 0 : 6;
      sink_gap_max = (ph % 3 == 2 || ph == 6) ? 0 : 6;
      // output held off while commands keep coming, input must back up
      if (ph == 3) stall_sink_req = 1'b1;

      for (int k = 0; k < 100; k++) begin
        if (ph == 5 && k == 50) drain();
        r      = $urandom_range(0, 99);
        w.pad  = '0;
        w.amp  = 16'($urandom);
        w.widx = 11'($urandom);
        w.exc  = 16'($urandom);
        w.mix  = rand_mix();
        if ($urandom_range(0, 7) == 0) w.exc = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        if (r < 3) begin
          op = OP_UNUSED;
        end else if (r < 18) begin
          op = OP_LOAD;
          if (loaded_prefix < MAX_LENGTH && $urandom_range(0, 9) < 7)
            w.widx = 11'(loaded_prefix);
        end else if (r < 28 && loaded_prefix >= active_len) begin
          op = OP_PLUCK;
          if ($urandom_range(0, 4) != 0) w.amp = 16'($urandom_range(0, 32768));
        end else if (r < 28 && active_len <= 256 && loaded_prefix < MAX_LENGTH) begin
          // excitation not loaded far enough yet for this ring
          op = OP_LOAD;
          w.widx = 11'(loaded_prefix);
        end else begin
          op = OP_TICK;
        end
        push_item(op, w, 1'b0, '0, 1'b0);
      end
    end

    drain();
    if (sample_q.size() != 0) begin
      $error("%0d samples never arrived", sample_q.size());
      errors++;
    end
    $display("covered %0d samples (%0d saturated), %0d plucks, %0d excitation loads",
             samples_seen, clips_seen, plucks_seen, loads_seen);
    $display("%0d register writes, ring lengths from 2 to 2048, %0d cycles",
             reg_writes, cycle_cnt);
    if (errors == 0) begin
      $display("tb_plucked_string_synth_unit OK");
    end else begin
      $display("tb_plucked_string_synth_unit NOT OK");
    end
    $finish;
  end

endmodule
